### design/hwmon_reading_converter_macros.svh
// ----------------------------------------------------------------------------
// hwmon_reading_converter_macros.svh
// Assertion macros shared by the checker of the reading converter.
// ----------------------------------------------------------------------------
`ifndef HWMON_READING_CONVERTER_MACROS_SVH
`define HWMON_READING_CONVERTER_MACROS_SVH

// Same-cycle implication, off during reset.
`define HRC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hwmon_reading_converter: check failed");

// Next-cycle implication, off during reset.
`define HRC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hwmon_reading_converter: check failed");

// Next-cycle implication that also holds across reset.
`define HRC_ASSERT_ALL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("hwmon_reading_converter: reset check failed");

`endif

### design/hrc_pkg.sv
// ----------------------------------------------------------------------------
// hrc_pkg
// Types and constants of the hardware-monitor reading converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hrc_pkg;

    typedef enum logic [1:0] {
        CMD_VOLTAGE = 2'd0,
        CMD_TEMP    = 2'd1,
        CMD_FAN     = 2'd2,
        CMD_PWM     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_VOLTAGE_STEP = 2'd0,
        CFG_DUAL_MODE    = 2'd1,
        CFG_BATTERY_CH   = 2'd2,
        CFG_PECI_MASK    = 2'd3
    } t_cfg_idx;

    localparam int READING_W    = 24;
    localparam int STEP_W       = 15;
    localparam int RAW_W        = 8;
    localparam int DEXP_W       = 3;
    localparam int FAN_QUO_W    = 21;
    localparam int DIV_STEPS    = 7;   // quotient bits per divider stage
    localparam int PWM_Y_W      = 15;
    localparam int PWM_Q_W      = 7;
    localparam int TEMP_W       = 10;

    localparam logic [STEP_W-1:0]    VRM8_STEP_UV   = 15'd16000;
    localparam logic [STEP_W-1:0]    VRM9_STEP_UV   = 15'd4880;
    localparam logic [READING_W-1:0] VRM9_OFFSET_UV = 24'd690000;
    localparam logic [FAN_QUO_W-1:0] FAN_DIVIDEND   = 21'd1350000;
    localparam logic [RAW_W-1:0]     FAN_SATURATED  = 8'hff;
    localparam logic [RAW_W-1:0]     FAN_UP_LIMIT   = 8'd192;
    localparam logic [RAW_W-1:0]     FAN_DOWN_LIMIT = 8'd96;
    localparam logic [DEXP_W-1:0]    DEXP_MAX       = 3'd7;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN_HD = -10'sd110;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_HD = 10'sd250;
    // floor(2^22/255): reciprocal for the percent divide, at most one low
    localparam logic [29:0] PWM_RECIP     = 30'd16448;
    localparam int          PWM_RECIP_SH  = 22;
    localparam logic [PWM_Y_W-1:0] PWM_DIV = 15'd255;

    typedef struct packed {
        logic [STEP_W-1:0] voltage_step_uv;
        logic              vcore_dual_mode;
        logic [3:0]        battery_channel;
        logic [1:0]        peci_mask;
    } t_cfg;

    typedef struct packed {
        t_cmd                  cmd;
        logic                  ok;
        logic [READING_W-1:0]  val;
        logic [DEXP_W-1:0]     nd;
        logic [DEXP_W-1:0]     dexp;
        logic                  sat;
        logic [RAW_W-1:0]      cnt;
        logic [RAW_W-1:0]      rem;
        logic [FAN_QUO_W-1:0]  quo;
        logic [PWM_Y_W-1:0]    pwm_y;
        logic [PWM_Q_W-1:0]    pwm_q;
    } t_item;

endpackage

`default_nettype wire

### design/hwmon_reading_converter.sv
// Converts raw hardware-monitor bytes into engineering units: voltages in
// microvolts, temperatures in half degrees Celsius, fan tach counts in rpm
// (plus a suggested divisor exponent) and PWM duty in whole percent. Every
// input word gives exactly one result word. The pipeline has five register
// stages, and a new word can be taken every cycle while o_stall is low. The
// depth is set by the fan divider, which resolves seven quotient bits in each
// of three stages between a conversion stage and the output register.
// Configuration registers are written through the write port and must only
// change while the pipeline is empty.
// ----------------------------------------------------------------------------
// hwmon_reading_converter
// Top level: configuration registers and the five-stage conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module hwmon_reading_converter import hrc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [STEP_W-1:0]      i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [1:0]             i_command,
    input  wire logic [3:0]             i_channel,
    input  wire logic [RAW_W-1:0]       i_raw_value,
    input  wire logic                   i_half_bit,
    input  wire logic [DEXP_W-1:0]      i_divisor_exponent,
    input  wire logic                   i_vrm9_select,
    input  wire logic                   i_battery_valid,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic signed [READING_W-1:0] o_reading,
    output logic                        o_valid_res,
    output logic [DEXP_W-1:0]           o_next_divisor_exponent
);

    t_cfg  r_cfg;
    logic  v1, v2, v3, v4;
    logic  s1, s2, s3, s4;
    t_item it1, it2, it3, it4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.voltage_step_uv <= 15'd8000;
            r_cfg.vcore_dual_mode <= 1'b0;
            r_cfg.battery_channel <= 4'd8;
            r_cfg.peci_mask       <= 2'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_VOLTAGE_STEP: r_cfg.voltage_step_uv <= i_cfg_data;
                CFG_DUAL_MODE:    r_cfg.vcore_dual_mode <= i_cfg_data[0];
                CFG_BATTERY_CH:   r_cfg.battery_channel <= i_cfg_data[3:0];
                CFG_PECI_MASK:    r_cfg.peci_mask       <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    hrc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_command          (i_command),
        .i_channel          (i_channel),
        .i_raw_value        (i_raw_value),
        .i_half_bit         (i_half_bit),
        .i_divisor_exponent (i_divisor_exponent),
        .i_vrm9_select      (i_vrm9_select),
        .i_battery_valid    (i_battery_valid),
        .o_valid            (v1),
        .o_item             (it1),
        .i_stall            (s1)
    );

    hrc_div_stage u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .o_stall (s1),
        .i_item  (it1),
        .o_valid (v2),
        .o_item  (it2),
        .i_stall (s2)
    );

    hrc_div_stage u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .o_stall (s2),
        .i_item  (it2),
        .o_valid (v3),
        .o_item  (it3),
        .i_stall (s3)
    );

    hrc_div_stage u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v3),
        .o_stall (s3),
        .i_item  (it3),
        .o_valid (v4),
        .o_item  (it4),
        .i_stall (s4)
    );

    hrc_back u_back (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_valid                 (v4),
        .o_stall                 (s4),
        .i_item                  (it4),
        .o_valid                 (o_valid),
        .o_reading               (o_reading),
        .o_valid_res             (o_valid_res),
        .o_next_divisor_exponent (o_next_divisor_exponent),
        .i_stall                 (i_stall)
    );

endmodule

`default_nettype wire

### design/hrc_front.sv
// ----------------------------------------------------------------------------
// hrc_front
// First stage: voltage and temperature conversion, fan divisor hint,
// percent estimate and divider setup.
// ----------------------------------------------------------------------------
`default_nettype none

module hrc_front import hrc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_command,
    input  wire logic [3:0]        i_channel,
    input  wire logic [RAW_W-1:0]  i_raw_value,
    input  wire logic              i_half_bit,
    input  wire logic [DEXP_W-1:0] i_divisor_exponent,
    input  wire logic              i_vrm9_select,
    input  wire logic              i_battery_valid,
    output logic                   o_valid,
    output t_item                  o_item,
    input  wire logic              i_stall
);

    logic                      r_valid;
    t_item                     r_item;
    t_item                     n_item;

    logic                      is_bat;
    logic                      is_vcore;
    logic [STEP_W-1:0]         mul_a;
    logic [22:0]               prod;
    logic [READING_W-1:0]      volt_val;
    logic                      volt_ok;
    logic                      low_ch;
    logic                      peci;
    logic signed [TEMP_W-1:0]  temp_hd;
    logic                      temp_ok;
    logic [15:0]               pwm_x;
    logic [29:0]               pwm_p;
    logic [DEXP_W-1:0]         nd;
    t_cmd                      cmd;

    assign cmd = t_cmd'(i_command);

    always_comb begin
        // Battery channel wins over the vcore formulas.
        is_bat   = (i_channel == i_cfg.battery_channel);
        is_vcore = i_cfg.vcore_dual_mode && (i_channel == 4'd0) && !is_bat;
        if (is_vcore) begin
            mul_a = i_vrm9_select ? VRM9_STEP_UV : VRM8_STEP_UV;
        end else begin
            mul_a = i_cfg.voltage_step_uv;
        end
        prod     = {8'd0, mul_a} * {15'd0, i_raw_value};
        volt_val = {1'b0, prod} + ((is_vcore && i_vrm9_select) ? VRM9_OFFSET_UV : '0);
        volt_ok  = is_bat ? i_battery_valid : (volt_val != '0);

        low_ch  = (i_channel < 4'd2);
        peci    = low_ch && i_cfg.peci_mask[i_channel[0]];
        temp_hd = $signed({i_raw_value[7], i_raw_value, 1'b0})
                + $signed({9'd0, i_half_bit & low_ch});
        temp_ok = (temp_hd >= TEMP_MIN_HD) && (temp_hd <= TEMP_MAX_HD) && !peci;

        pwm_x = {8'd0, i_raw_value} * 16'd200 + 16'd255;
        pwm_p = {15'd0, pwm_x[15:1]} * PWM_RECIP;

        nd = i_divisor_exponent;
        if ((i_raw_value > FAN_UP_LIMIT) && (nd < DEXP_MAX)) begin
            nd = nd + 3'd1;
        end
        if ((i_raw_value < FAN_DOWN_LIMIT) && (nd > 3'd0)) begin
            nd = nd - 3'd1;
        end

        n_item       = '0;
        n_item.cmd   = cmd;
        n_item.dexp  = i_divisor_exponent;
        n_item.cnt   = i_raw_value;
        n_item.sat   = (i_raw_value == FAN_SATURATED);
        n_item.rem   = '0;
        n_item.quo   = FAN_DIVIDEND;
        n_item.pwm_y = pwm_x[15:1];
        n_item.pwm_q = pwm_p[PWM_RECIP_SH+PWM_Q_W-1:PWM_RECIP_SH];
        case (cmd)
            CMD_VOLTAGE: begin
                n_item.val = volt_val;
                n_item.ok  = volt_ok;
            end
            CMD_TEMP: begin
                n_item.val = {{(READING_W-TEMP_W){temp_hd[TEMP_W-1]}}, temp_hd};
                n_item.ok  = temp_ok;
            end
            CMD_FAN: begin
                n_item.ok = (i_raw_value != '0);
                n_item.nd = nd;
            end
            CMD_PWM: begin
                n_item.ok = 1'b1;
            end
            default: begin
                n_item.ok = 1'b0;
            end
        endcase
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### design/hrc_div_stage.sv
// ----------------------------------------------------------------------------
// hrc_div_stage
// One register stage of the fan divider: DIV_STEPS restoring steps of the
// constant dividend over the tach count.
// ----------------------------------------------------------------------------
`default_nettype none

module hrc_div_stage import hrc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_item i_item,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_stall
);

    logic         r_valid;
    t_item        r_item;
    t_item        n_item;
    logic [RAW_W:0] trial;

    // Dividend bits leave the top of quo while quotient bits enter below.
    always_comb begin
        n_item = i_item;
        trial  = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {n_item.rem, n_item.quo[FAN_QUO_W-1]};
            if (trial >= {1'b0, n_item.cnt}) begin
                trial = trial - {1'b0, n_item.cnt};
                n_item.quo = {n_item.quo[FAN_QUO_W-2:0], 1'b1};
            end else begin
                n_item.quo = {n_item.quo[FAN_QUO_W-2:0], 1'b0};
            end
            n_item.rem = trial[RAW_W-1:0];
        end
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### design/hrc_back.sv
// ----------------------------------------------------------------------------
// hrc_back
// Last stage: fan scaling, percent rounding fix-up, result select and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hrc_back import hrc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire t_item                i_item,
    output logic                      o_valid,
    output logic signed [READING_W-1:0] o_reading,
    output logic                      o_valid_res,
    output logic [DEXP_W-1:0]         o_next_divisor_exponent,
    input  wire logic                 i_stall
);

    logic                   r_valid;
    logic [READING_W-1:0]   r_reading;
    logic                   r_ok;
    logic [DEXP_W-1:0]      r_nd;
    logic [READING_W-1:0]   n_reading;
    logic [FAN_QUO_W-1:0]   fan_rpm;
    logic [PWM_Y_W-1:0]     pwm_r;
    logic [PWM_Q_W-1:0]     pwm_q;

    always_comb begin
        // floor(floor(a/b)/2^d) equals floor(a/(b*2^d))
        fan_rpm = i_item.quo >> i_item.dexp;
        pwm_r   = i_item.pwm_y - (({8'd0, i_item.pwm_q} << 8) - {8'd0, i_item.pwm_q});
        pwm_q   = i_item.pwm_q + ((pwm_r >= PWM_DIV) ? 7'd1 : 7'd0);
        case (i_item.cmd)
            CMD_VOLTAGE, CMD_TEMP: n_reading = i_item.val;
            CMD_FAN:   n_reading = i_item.sat ? '0 : {3'd0, fan_rpm};
            CMD_PWM:   n_reading = {17'd0, pwm_q};
            default:   n_reading = '0;
        endcase
        if (!i_item.ok) begin
            n_reading = '0;
        end
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_reading <= n_reading;
            r_ok      <= i_item.ok;
            r_nd      <= i_item.nd;
        end
    end

    assign o_valid                 = r_valid;
    assign o_reading               = $signed(r_reading);
    assign o_valid_res             = r_ok;
    assign o_next_divisor_exponent = r_nd;

endmodule

`default_nettype wire

### design/hrc_checker.sv
// ----------------------------------------------------------------------------
// hrc_checker
// Port-level checks of the reading converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hwmon_reading_converter_macros.svh"

module hrc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [23:0] o_reading,
    input wire logic        o_valid_res,
    input wire logic [2:0]  o_next_divisor_exponent
);

    // A held result word keeps all of its fields.
    `HRC_ASSERT_NXT(a_hold, o_valid && i_stall, o_valid && $stable(o_reading) && $stable(o_valid_res) && $stable(o_next_divisor_exponent))

    // An invalid result carries a zero reading.
    `HRC_ASSERT_IMP(a_invalid_zero, o_valid && !o_valid_res, o_reading == 24'd0)

    // Input back-pressure only when the output register is full and stalled.
    `HRC_ASSERT_IMP(a_stall_source, o_stall, o_valid && i_stall)

    // Reset empties the pipeline.
    `HRC_ASSERT_ALL(a_reset_empty, !i_rst_n, !o_valid && !o_stall)

endmodule

bind hwmon_reading_converter hrc_checker u_hrc_checker (.*);

`default_nettype wire
